### hdl/msxt_pkg.sv
package msxt_pkg;

	localparam int VALUE_W = 32;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] best_xor;
		logic               end_of_array;
		logic               overflow;
	} result_t;

	// Control part of a token moving along the chain. For a query the flag means the walk
	// is still on a stored path; for an insert it means the node was allocated just now.
	typedef struct packed {
		logic valid;
		logic flag;
	} tok_ctl_t;

endpackage

### hdl/msxt_ram.sv
module msxt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1025
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/msxt_cell.sv
module msxt_cell #(
	parameter int KEY_BITS = 32,
	parameter int BIT_POS  = 31,
	parameter int NODE_W   = 11,
	parameter int DEPTH    = 1025
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  logic                    key_bit,
	input  msxt_pkg::tok_ctl_t      q_in_ctl,
	input  logic [NODE_W-1:0]       q_in_node,
	input  logic [KEY_BITS-1:0]     q_in_acc,
	input  msxt_pkg::tok_ctl_t      i_in_ctl,
	input  logic [NODE_W-1:0]       i_in_node,
	output msxt_pkg::tok_ctl_t      q_out_ctl,
	output logic [NODE_W-1:0]       q_out_node,
	output logic [KEY_BITS-1:0]     q_out_acc,
	output msxt_pkg::tok_ctl_t      i_out_ctl,
	output logic [NODE_W-1:0]       i_out_node
);

	import msxt_pkg::*;

	localparam int EW = 2 * (NODE_W + 1);
	localparam int CW = $clog2(DEPTH + 1);

	logic                q_vld_s1;
	logic                q_alive_s1;
	logic [KEY_BITS-1:0] q_acc_s1;
	logic                i_vld_s1;
	logic                i_fresh_s1;
	logic [NODE_W-1:0]   i_node_s1;
	logic [CW-1:0]       cnt_q;
	tok_ctl_t            q_out_ctl_q;
	tok_ctl_t            i_out_ctl_q;
	logic [NODE_W-1:0]   q_out_node_q;
	logic [KEY_BITS-1:0] q_out_acc_q;
	logic [NODE_W-1:0]   i_out_node_q;

	logic [NODE_W-1:0]   raddr;
	logic [EW-1:0]       rdata;
	logic [EW-1:0]       wdata;
	logic                we;

	logic                rv0, rv1;
	logic [NODE_W-1:0]   rc0, rc1;
	logic                v_want, v_same;
	logic [NODE_W-1:0]   c_want, c_same;
	logic                q_nxt_alive;
	logic [NODE_W-1:0]   q_nxt_node;
	logic [KEY_BITS-1:0] q_nxt_acc;

	logic [EW-1:0]       ie;
	logic                ev0, ev1;
	logic [NODE_W-1:0]   ec0, ec1;
	logic                hit;
	logic [NODE_W-1:0]   hit_c;
	logic [NODE_W-1:0]   new_c;

	// The insert token follows the query token in the next cycle, so the read port is shared.
	assign raddr = q_in_ctl.valid ? q_in_node : i_in_node;

	msxt_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(i_node_s1),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		rv0 = rdata[NODE_W];
		rc0 = rdata[NODE_W-1:0];
		rv1 = rdata[EW-1];
		rc1 = rdata[EW-2:NODE_W+1];
		v_want = key_bit ? rv0 : rv1;
		c_want = key_bit ? rc0 : rc1;
		v_same = key_bit ? rv1 : rv0;
		c_same = key_bit ? rc1 : rc0;
		q_nxt_acc   = q_acc_s1;
		q_nxt_node  = c_same;
		q_nxt_alive = 1'b0;
		if (q_alive_s1 && v_want) begin
			q_nxt_acc[BIT_POS] = 1'b1;
			q_nxt_node         = c_want;
			q_nxt_alive        = 1'b1;
		end else if (q_alive_s1 && v_same) begin
			q_nxt_alive = 1'b1;
		end
	end

	always_comb begin
		ie    = i_fresh_s1 ? '0 : rdata;
		ev0   = ie[NODE_W];
		ec0   = ie[NODE_W-1:0];
		ev1   = ie[EW-1];
		ec1   = ie[EW-2:NODE_W+1];
		hit   = key_bit ? ev1 : ev0;
		hit_c = key_bit ? ec1 : ec0;
		new_c = cnt_q[NODE_W-1:0];
		wdata = key_bit ? {1'b1, new_c, ev0, ec0} : {ev1, ec1, 1'b1, new_c};
		we    = i_vld_s1 && !hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_s1    <= 1'b0;
			i_vld_s1    <= 1'b0;
			q_out_ctl_q <= '0;
			i_out_ctl_q <= '0;
			cnt_q       <= '0;
		end else begin
			q_vld_s1          <= q_in_ctl.valid;
			i_vld_s1          <= i_in_ctl.valid;
			q_out_ctl_q.valid <= q_vld_s1;
			q_out_ctl_q.flag  <= q_nxt_alive;
			i_out_ctl_q.valid <= i_vld_s1;
			i_out_ctl_q.flag  <= !hit;
			if (clr) begin
				cnt_q <= '0;
			end else if (we) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		q_alive_s1   <= q_in_ctl.flag;
		q_acc_s1     <= q_in_acc;
		i_fresh_s1   <= i_in_ctl.flag;
		i_node_s1    <= i_in_node;
		q_out_node_q <= q_nxt_node;
		q_out_acc_q  <= q_nxt_acc;
		i_out_node_q <= hit ? hit_c : new_c;
	end

	assign q_out_ctl  = q_out_ctl_q;
	assign q_out_node = q_out_node_q;
	assign q_out_acc  = q_out_acc_q;
	assign i_out_ctl  = i_out_ctl_q;
	assign i_out_node = i_out_node_q;

endmodule

### hdl/max_subarray_xor_trie.sv
// Maximum subarray XOR of a stream of array elements, one result item per input item.
// Input channel item_valid/item_ready carries item (value, is_last); the output channel
// result_valid/result_ready carries result (best_xor, end_of_array, overflow).
// Only the low KEY_BITS bits of each value take part.
// The trie of prefix XORs is split over a row of KEY_BITS cells, one per key bit, each with
// its own node memory of MAX_ITEMS+1 entries. An item sends a query token and, in the next
// cycle, an insert token down the row; each cell passes a token through its s1 and output registers.
// A result is ready once the query token, and the insert token if any, have left the row, and the
// next item can be accepted in that same cycle, so items do not overlap in the row; an item
// beyond the item limit skips the insert. The walk through the row of cells sets the pace.
// After reset, and after the item marked last, the trie is emptied and seeded with the
// prefix zero; no item is accepted until the seed insert has left the row of cells.
// The result sits in an output register; while the receiver stalls, the next item is still
// accepted and worked on, and the block waits only when that next result is ready.
module max_subarray_xor_trie #(
	parameter int MAX_ITEMS = 1024,
	parameter int KEY_BITS  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  msxt_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output msxt_pkg::result_t result
);

	import msxt_pkg::*;

	localparam int DEPTH  = MAX_ITEMS + 1;
	localparam int NODE_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_SEED  = 3'd1;
	localparam logic [2:0] S_SEEDW = 3'd2;
	localparam logic [2:0] S_IDLE  = 3'd3;
	localparam logic [2:0] S_QRY   = 3'd4;
	localparam logic [2:0] S_INS   = 3'd5;
	localparam logic [2:0] S_WAIT  = 3'd6;

	logic [2:0]          state_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] prefix_q;
	logic [KEY_BITS-1:0] best_q;
	logic [KEY_BITS-1:0] qres_q;
	logic [CNT_W-1:0]    items_q;
	logic                ovf_q;
	logic                last_q;
	logic                ins_q;
	logic                qd_q;
	logic                id_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [KEY_BITS-1:0] prefix_n;
	logic [KEY_BITS-1:0] best_n;
	logic                fin;
	logic                clr;

	tok_ctl_t            q_ctl  [KEY_BITS+1];
	logic [NODE_W-1:0]   q_node [KEY_BITS+1];
	logic [KEY_BITS-1:0] q_acc  [KEY_BITS+1];
	tok_ctl_t            i_ctl  [KEY_BITS+1];
	logic [NODE_W-1:0]   i_node [KEY_BITS+1];

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign clr          = (state_q == S_CLR);

	assign prefix_n = prefix_q ^ item.value[KEY_BITS-1:0];
	assign best_n   = (qres_q > best_q) ? qres_q : best_q;
	assign fin      = (state_q == S_WAIT) && qd_q && (id_q || !ins_q)
	                  && (!result_valid_q || result_ready);

	always_comb begin
		q_ctl[0].valid = (state_q == S_QRY);
		q_ctl[0].flag  = 1'b1;
		q_node[0]      = '0;
		q_acc[0]       = '0;
		i_ctl[0].valid = (state_q == S_SEED) || ((state_q == S_INS) && ins_q);
		i_ctl[0].flag  = (state_q == S_SEED);
		i_node[0]      = '0;
	end

	for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
		msxt_cell #(
			.KEY_BITS(KEY_BITS),
			.BIT_POS (KEY_BITS - 1 - g),
			.NODE_W  (NODE_W),
			.DEPTH   (DEPTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clr       (clr),
			.key_bit   (key_q[KEY_BITS-1-g]),
			.q_in_ctl  (q_ctl[g]),
			.q_in_node (q_node[g]),
			.q_in_acc  (q_acc[g]),
			.i_in_ctl  (i_ctl[g]),
			.i_in_node (i_node[g]),
			.q_out_ctl (q_ctl[g+1]),
			.q_out_node(q_node[g+1]),
			.q_out_acc (q_acc[g+1]),
			.i_out_ctl (i_ctl[g+1]),
			.i_out_node(i_node[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			key_q          <= '0;
			prefix_q       <= '0;
			best_q         <= '0;
			qres_q         <= '0;
			items_q        <= '0;
			ovf_q          <= 1'b0;
			last_q         <= 1'b0;
			ins_q          <= 1'b0;
			qd_q           <= 1'b0;
			id_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && !fin) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					state_q <= S_SEED;
				end
				S_SEED: begin
					state_q <= S_SEEDW;
				end
				S_SEEDW: begin
					if (i_ctl[KEY_BITS].valid) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						key_q    <= prefix_n;
						prefix_q <= prefix_n;
						last_q   <= item.is_last;
						if (items_q < CNT_W'(MAX_ITEMS)) begin
							ins_q   <= 1'b1;
							items_q <= items_q + CNT_W'(1);
						end else begin
							ins_q <= 1'b0;
							ovf_q <= 1'b1;
						end
						state_q <= S_QRY;
					end
				end
				S_QRY: begin
					qd_q    <= 1'b0;
					id_q    <= 1'b0;
					state_q <= S_INS;
				end
				S_INS: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (q_ctl[KEY_BITS].valid) begin
						qd_q   <= 1'b1;
						qres_q <= q_acc[KEY_BITS];
					end
					if (i_ctl[KEY_BITS].valid) begin
						id_q <= 1'b1;
					end
					if (fin) begin
						result_valid_q <= 1'b1;
						if (last_q) begin
							key_q    <= '0;
							prefix_q <= '0;
							best_q   <= '0;
							items_q  <= '0;
							ovf_q    <= 1'b0;
							state_q  <= S_CLR;
						end else begin
							best_q  <= best_n;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.best_xor     <= VALUE_W'(best_n);
			result_q.end_of_array <= last_q;
			result_q.overflow     <= ovf_q;
		end
	end

	a_idle_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!q_ctl[KEY_BITS].valid && !i_ctl[KEY_BITS].valid))
		else $error("A token left the cell row while the block was idle.");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WAIT) && !ins_q) |-> !i_ctl[KEY_BITS].valid)
		else $error("An insert ran for an item beyond the item limit.");

	a_items_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= CNT_W'(MAX_ITEMS))
		else $error("Item count passed the item limit.");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && !last_q) |=> (best_q >= $past(best_q)))
		else $error("Running maximum decreased within an array.");

endmodule

### bench/max_subarray_xor_trie_tb.sv
module max_subarray_xor_trie_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msxt_pkg::*;

	localparam int MAX_ITEMS = 1024;
	localparam int KEY_BITS = 32;
	localparam logic [31:0] KEY_MASK = 32'((64'd1 << KEY_BITS) - 64'd1);
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 40;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t         expected_results[$];
	logic [31:0]     stored_prefixes[$];
	logic [31:0]     running_xor;
	logic [31:0]     best_xor_acc;
	int unsigned     array_len;
	bit              array_overflowed;
	logic [31:0]     last_value;
	bit              sender_idle;
	bit              receiver_idle;
	int              pressure_hold;
	int              mismatch_count;
	int              quiet_cycles;

	max_subarray_xor_trie #(
		.MAX_ITEMS(MAX_ITEMS),
		.KEY_BITS (KEY_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void restart_prefix_set();
		stored_prefixes = {32'h0};
		running_xor = '0;
		best_xor_acc = '0;
		array_len = 0;
		array_overflowed = 1'b0;
	endfunction

	// The largest XOR against any stored prefix equals what the trie walk finds.
	function automatic result_t predict_best_xor(input item_t it);
		logic [31:0] probe;
		result_t     r;
		running_xor = (running_xor ^ it.value) & KEY_MASK;
		probe = '0;
		foreach (stored_prefixes[i]) begin
			if ((stored_prefixes[i] ^ running_xor) > probe) begin
				probe = stored_prefixes[i] ^ running_xor;
			end
		end
		if (probe > best_xor_acc) begin
			best_xor_acc = probe;
		end
		if (array_len < MAX_ITEMS) begin
			stored_prefixes.push_back(running_xor);
			array_len++;
		end else begin
			array_overflowed = 1'b1;
		end
		r.best_xor = best_xor_acc;
		r.end_of_array = it.is_last;
		r.overflow = array_overflowed;
		if (it.is_last) begin
			restart_prefix_set();
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom();
			4: v = $urandom_range(0, 15);
			5: v = 32'h1 << $urandom_range(0, 31);
			6: v = ~(32'h1 << $urandom_range(0, 31));
			7: v = last_value;
			8: v = {4'($urandom_range(0, 15)), 28'h0};
			default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		last_value = v;
		return v;
	endfunction

	task automatic send_item(input logic [31:0] v, input logic last);
		int    gap;
		item_t pkt;
		pkt.value = v;
		pkt.is_last = last;
		gap = sender_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= pkt;
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(predict_best_xor(pkt));
	endtask

	task automatic send_array(input int len);
		for (int i = 0; i < len; i++) begin
			send_item(pick_value(), i == len - 1);
		end
	endtask

	task automatic test_directed();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		send_item(32'h0000_0000, 1'b1);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0001, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b0);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b1);
		send_item(32'h1234_5678, 1'b0);
		send_item(32'h1234_5678, 1'b0);
		send_item(32'h5555_5555, 1'b1);
		send_item(32'h0000_0001, 1'b0);
		send_item(32'h0000_0020, 1'b0);
		send_item(32'h0000_2000, 1'b0);
		send_item(32'h0020_0000, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b1);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b1);
	endtask

	task automatic test_pressure();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		pressure_hold = 400;
		send_array(12);
	endtask

	task automatic test_random_arrays();
		int sent;
		int len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sender_idle = $urandom_range(0, 3) != 0;
			receiver_idle = $urandom_range(0, 3) != 0;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
			send_array(len);
			sent += len;
		end
	endtask

	// One array runs past the trie's capacity; the following short array must start clean.
	task automatic test_overflow();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		send_array(MAX_ITEMS + $urandom_range(1, 6));
		send_array(3);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		pressure_hold = 0;
		mismatch_count = 0;
		last_value = '0;
		restart_prefix_set();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pressure();
		test_random_arrays();
		test_overflow();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2 * KEY_BITS + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		int      stall;
		result_t want;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (pressure_hold > 0) begin
				stall = pressure_hold;
				pressure_hold = 0;
			end else begin
				stall = receiver_idle ? $urandom_range(0, 19) : 0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			if (expected_results.size() == 0) begin
				$error("result item arrived with no input item pending");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.best_xor !== want.best_xor) begin
					$error("best_xor: expected %h, actual %h", want.best_xor, result.best_xor);
					mismatch_count++;
				end
				if (result.end_of_array !== want.end_of_array) begin
					$error("end_of_array: expected %b, actual %b",
						want.end_of_array, result.end_of_array);
					mismatch_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %b, actual %b", want.overflow, result.overflow);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
